### sv/acc_pkg.sv
// Shared types and constants for the APDU case classifier.
// Depends on nothing; every other module of the block imports it.
`default_nettype none

package acc_pkg;

   // Byte count saturates at the top of its 17-bit range.
   localparam int COUNT_W    = 17;
   localparam int HEAD_BYTES = 7;
   localparam int TAIL_BYTES = 3;
   localparam int HEAD_IDX_W = 3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Case codes.
   localparam logic [5:0] CASE_NONE = 6'h00;
   localparam logic [5:0] CASE_1    = 6'h01;
   localparam logic [5:0] CASE_2S   = 6'h02;
   localparam logic [5:0] CASE_3S   = 6'h03;
   localparam logic [5:0] CASE_4S   = 6'h04;
   localparam logic [5:0] CASE_2E   = 6'h12;
   localparam logic [5:0] CASE_3E   = 6'h13;
   localparam logic [5:0] CASE_4E   = 6'h14;
   localparam logic [5:0] CASE_4E3  = 6'h24;

   localparam logic [2:0] OFFSET_NONE  = 3'd0;
   localparam logic [2:0] OFFSET_SHORT = 3'd5;
   localparam logic [2:0] OFFSET_EXT   = 3'd7;

   localparam logic [16:0] LE_SHORT_MAX = 17'h00100;
   localparam logic [16:0] LE_EXT_MAX   = 17'h10000;

   // One finished APDU as the front hands it over.
   typedef struct packed {
      logic [COUNT_W-1:0]                count;
      logic [HEAD_BYTES-1:0][7:0]        head;
      logic [TAIL_BYTES-1:0][7:0]        tail;   // tail[2] is the newest byte
   } frame_type;

   // One classified result.
   typedef struct packed {
      logic [2:0]  data_offset;
      logic [16:0] expected_length;
      logic [15:0] command_length;
      logic [7:0]  param_two;
      logic [7:0]  param_one;
      logic [7:0]  instruction_byte;
      logic [7:0]  class_byte;
      logic        is_extended;
      logic [5:0]  case_code;
   } result_type;

   localparam int RESULT_W = $bits(result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### sv/acc_front.sv
// Front part: accepts APDU bytes, keeps count, head and tail bytes.
// Depends on acc_pkg; pushes one frame into the queue per last byte.
`default_nettype none

module acc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [7:0]       req_tdata,
   input  wire logic             req_tlast,
   input  wire logic             queue_full,
   output logic                  push,
   output acc_pkg::frame_type    push_frame
);
   import acc_pkg::*;

   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [HEAD_BYTES-1:0][7:0] head_ff, head_in;
   logic [TAIL_BYTES-1:0][7:0] tail_ff, tail_in;
   logic                       accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      head_in = head_ff;
      if (count_ff < COUNT_W'(HEAD_BYTES)) begin
         head_in[count_ff[HEAD_IDX_W-1:0]] = req_tdata;
      end
      tail_in[0] = tail_ff[1];
      tail_in[1] = tail_ff[2];
      tail_in[2] = req_tdata;
      count_in   = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   end

   assign push       = accept && req_tlast;
   assign push_frame = '{count: count_in, head: head_in, tail: tail_in};

   // Clear all state after the last byte so the next APDU starts fresh.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            count_ff <= '0;
            head_ff  <= '0;
            tail_ff  <= '0;
         end else begin
            count_ff <= count_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
         end
      end
   end

endmodule

`default_nettype wire

### sv/acc_queue.sv
// Short queue of finished frames between front and back.
// Depends on acc_pkg for the frame type.
`default_nettype none

module acc_queue #(
   parameter int Depth = acc_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  acc_pkg::frame_type    push_frame,
   output logic                  full,
   input  wire logic             pop,
   output acc_pkg::frame_type    pop_frame,
   output logic                  not_empty
);
   import acc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   frame_type       mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] cnt_ff;
   logic            do_push, do_pop;

   assign full      = (cnt_ff == FullCnt);
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_frame = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### sv/acc_back.sv
// Back part: classifies one queued frame and holds it in the output register.
// Depends on acc_pkg for frame and result types and case codes.
`default_nettype none

module acc_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              frame_valid,
   input  acc_pkg::frame_type                     frame,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [acc_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic                                   rsp_tuser
);
   import acc_pkg::*;

   logic [COUNT_W-1:0] len;
   logic [7:0]         b0;
   logic [15:0]        ext_lc;
   logic [15:0]        last2;
   logic [16:0]        le_short_b0, le_short_tail, le_ext_lc, le_ext_last2;
   logic [5:0]         code;
   logic [15:0]        lc;
   logic [16:0]        le;
   result_type         res;
   logic               bad;

   result_type         res_ff;
   logic               bad_ff;
   logic               valid_ff;

   assign len    = frame.count;
   assign b0     = frame.head[4];
   assign ext_lc = {frame.head[5], frame.head[6]};
   assign last2  = {frame.tail[1], frame.tail[2]};

   // Encoded zero Le stands for the maximum.
   assign le_short_b0   = (b0 != 8'h00) ? {9'd0, b0} : LE_SHORT_MAX;
   assign le_short_tail = (frame.tail[2] != 8'h00) ? {9'd0, frame.tail[2]} : LE_SHORT_MAX;
   assign le_ext_lc     = (ext_lc != 16'h0000) ? {1'b0, ext_lc} : LE_EXT_MAX;
   assign le_ext_last2  = (last2 != 16'h0000) ? {1'b0, last2} : LE_EXT_MAX;

   always_comb begin
      code = CASE_NONE;
      lc   = '0;
      le   = '0;
      if (len == COUNT_W'(4)) begin
         code = CASE_1;
      end else if (len == COUNT_W'(5)) begin
         code = CASE_2S;
         le   = le_short_b0;
      end else if (b0 != 8'h00 && len == COUNT_W'(5) + COUNT_W'(b0)) begin
         code = CASE_3S;
         lc   = {8'd0, b0};
      end else if (b0 != 8'h00 && len == COUNT_W'(6) + COUNT_W'(b0)) begin
         code = CASE_4S;
         lc   = {8'd0, b0};
         le   = le_short_tail;
      end else if (b0 == 8'h00 && len >= COUNT_W'(7)) begin
         if (len == COUNT_W'(7)) begin
            code = CASE_2E;
            le   = le_ext_lc;
         end else if (ext_lc != 16'h0000 && len == COUNT_W'(7) + COUNT_W'(ext_lc)) begin
            code = CASE_3E;
            lc   = ext_lc;
         end else if (ext_lc != 16'h0000 && len == COUNT_W'(9) + COUNT_W'(ext_lc)) begin
            code = CASE_4E;
            lc   = ext_lc;
            le   = le_ext_last2;
         end else if (ext_lc != 16'h0000 && len == COUNT_W'(10) + COUNT_W'(ext_lc)
                      && frame.tail[0] == 8'h00) begin
            code = CASE_4E3;
            lc   = ext_lc;
            le   = le_ext_last2;
         end
      end
   end

   always_comb begin
      bad = (code == CASE_NONE);
      res = '0;
      if (!bad) begin
         res.case_code        = code;
         res.is_extended      = (code == CASE_2E) || (code == CASE_3E) ||
                                (code == CASE_4E) || (code == CASE_4E3);
         res.class_byte       = frame.head[0];
         res.instruction_byte = frame.head[1];
         res.param_one        = frame.head[2];
         res.param_two        = frame.head[3];
         res.command_length   = lc;
         res.expected_length  = le;
         if (lc == 16'h0000) begin
            res.data_offset = OFFSET_NONE;
         end else if (res.is_extended) begin
            res.data_offset = OFFSET_EXT;
         end else begin
            res.data_offset = OFFSET_SHORT;
         end
      end
   end

   // Take a new frame whenever the output register is empty or being drained.
   assign pop = frame_valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res;
         bad_ff <= bad;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(res_ff);
   assign rsp_tuser  = bad_ff;

endmodule

`default_nettype wire

### sv/apdu_case_classifier_top.sv
// Top level of the command APDU case classifier.
// Depends on acc_pkg, acc_front, acc_queue and acc_back.
`default_nettype none

// Channel  | Dir | Ports                               | Item
// ---------+-----+-------------------------------------+--------------------------------
// req      | in  | req_tvalid/tready/tdata[7:0]/tlast  | one APDU byte, tlast on the last
// rsp      | out | rsp_tvalid/tready/tdata[79:0]/tuser | one classified APDU per tlast byte
//
// The front takes one byte per cycle while req_tready is high; each APDU's
// frame enters the queue on its last byte and is classified into the output
// register when popped. The queue between front and back holds QueueDepth
// frames; only its filling, by a stalled rsp side, drops req_tready.
// Reset is synchronous and active high; it empties the queue, the output
// register and the byte counter.

module apdu_case_classifier_top #(
   parameter int QueueDepth = acc_pkg::QUEUE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req_tdata: [7:0] data_byte; req_tlast: last_byte
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [7:0]                    req_tdata,
   input  wire logic                          req_tlast,
   // rsp_tdata: [5:0] case_code, [6] is_extended, [14:7] class_byte,
   // [22:15] instruction_byte, [30:23] param_one, [38:31] param_two,
   // [54:39] command_length, [71:55] expected_length, [74:72] data_offset,
   // [79:75] zero
   // rsp_tuser: bad_format
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [acc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);
   import acc_pkg::*;

   logic      push;
   frame_type push_frame;
   logic      queue_full;
   logic      pop;
   frame_type pop_frame;
   logic      queue_not_empty;

   // Gather the bytes of each APDU; hand over the frame on its last byte.
   acc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_frame (push_frame)
   );

   // Decouple byte intake from result delivery.
   acc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (queue_full),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .not_empty  (queue_not_empty)
   );

   // Classify and hold the result until the rsp side takes it.
   acc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (queue_not_empty),
      .frame       (pop_frame),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

`default_nettype wire
